[rtl/core/mcs_pkg.sv]
`default_nettype none

package mcs_pkg;

  // Default structure sizes
  localparam int unsigned DIM_BITS_DEF   = 14;
  localparam int unsigned MAX_LEVELS_DEF = 16;

  // Fixed field widths
  localparam int unsigned DEPTH_W = 11;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned FMT_W   = 32;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned FULL_W  = 4;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Block-compressed four-character codes
  localparam logic [FMT_W-1:0] FMT_DXT1 = 32'h3154_5844;
  localparam logic [FMT_W-1:0] FMT_DXT5 = 32'h3554_5844;

  // Bytes per sizing unit (pixel or 4x4 block)
  typedef enum logic [2:0] {
    SCL_ZERO,
    SCL_X1,
    SCL_X2,
    SCL_X3,
    SCL_X4,
    SCL_X8,
    SCL_X16
  } scale_e;

  typedef struct packed {
    logic   dxt;
    scale_e scale;
  } fmt_info_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_XY,
    BK_MUL_Z,
    BK_ACC,
    BK_DONE
  } back_state_e;

  // Format code to sizing rule
  function automatic fmt_info_t classify_fmt(input logic [FMT_W-1:0] code);
    fmt_info_t info;
    info.dxt   = 1'b0;
    info.scale = SCL_ZERO;
    if (code >= FMT_DXT1 && code <= FMT_DXT5) begin
      info.dxt   = 1'b1;
      info.scale = (code == FMT_DXT1) ? SCL_X8 : SCL_X16;
    end else begin
      case (code) inside
        32'd20: info.scale = SCL_X3;
        32'd21, 32'd22, 32'd62, 32'd63, 32'd64, 32'd71, 32'd75, 32'd77, 32'd79,
        32'd102: info.scale = SCL_X4;
        32'd23, 32'd24, 32'd25, 32'd26, 32'd29, 32'd30, 32'd40, 32'd51, 32'd60,
        32'd61, 32'd70, 32'd73, 32'd80, 32'd101: info.scale = SCL_X2;
        32'd27, 32'd28, 32'd41, 32'd50, 32'd52: info.scale = SCL_X1;
        default: info.scale = SCL_ZERO;
      endcase
    end
    return info;
  endfunction

endpackage

`default_nettype wire

[rtl/core/mcs_if.sv]
`default_nettype none

// Texture description channel
interface mcs_in_if import mcs_pkg::*; #(
  parameter int unsigned DIM_BITS = DIM_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] width;
  logic [DIM_BITS-1:0] height;
  logic [DEPTH_W-1:0]  depth;
  logic [COUNT_W-1:0]  level_count;
  logic [FMT_W-1:0]    format_code;

  modport source (
    output valid, width, height, depth, level_count, format_code,
    input  ready
  );
  modport sink (
    input  valid, width, height, depth, level_count, format_code,
    output ready
  );
endinterface

// Chain size result channel
interface mcs_out_if import mcs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_bytes;
  logic               overflowed;
  logic [FULL_W-1:0]  full_levels;

  modport source (
    output valid, total_bytes, overflowed, full_levels,
    input  ready
  );
  modport sink (
    input  valid, total_bytes, overflowed, full_levels,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/mip_chain_size_calculator.sv]
// The sequencer pops a job while idle, then for each of the L levels multiplies width x
// height and area x depth on one shared multiplier and accumulates the level size; L is the
// clamped level count (0 to MAX_LEVELS). The result stays valid until it is taken, and no new
// job is popped before then; a two-entry job queue lets the input side run ahead. Reset is
// asynchronous, active low, and empties the queue and returns the sequencer to idle; no
// clearing pass.
`default_nettype none

module mip_chain_size_calculator import mcs_pkg::*; #(
  parameter int unsigned DIM_BITS   = DIM_BITS_DEF,
  parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mcs_in_if.sink    item_i,
  mcs_out_if.source result_o
);
  localparam int unsigned CNT_W = $clog2(MAX_LEVELS + 1);
  localparam int unsigned JOB_W = 2 * DIM_BITS + DEPTH_W + CNT_W
                                  + $bits(fmt_info_t) + FULL_W;

  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [JOB_W-1:0] push_job, pop_job;

  // Classify and pack incoming transactions
  mcs_front #(
    .DIM_BITS   (DIM_BITS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_front (
    .item_i       (item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .job_o        (push_job)
  );

  // Job queue
  mcs_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_job),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_job)
  );

  // Per-level sizing and accumulation
  mcs_back #(
    .DIM_BITS   (DIM_BITS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .job_i       (pop_job),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

[rtl/core/mcs_fifo.sv]
`default_nettype none

module mcs_fifo import mcs_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output logic      [WIDTH-1:0] rd_data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mcs_front.sv]
`default_nettype none

module mcs_front import mcs_pkg::*; #(
  parameter  int unsigned DIM_BITS   = DIM_BITS_DEF,
  parameter  int unsigned MAX_LEVELS = MAX_LEVELS_DEF,
  localparam int unsigned CNT_W      = $clog2(MAX_LEVELS + 1),
  localparam int unsigned JOB_W      = 2 * DIM_BITS + DEPTH_W + CNT_W
                                       + $bits(fmt_info_t) + FULL_W
) (
  mcs_in_if.sink           item_i,
  output logic             push_valid_o,
  input  wire logic        push_ready_i,
  output logic [JOB_W-1:0] job_o
);
  localparam int unsigned MAX_W = (DIM_BITS > DEPTH_W) ? DIM_BITS : DEPTH_W;
  localparam int unsigned BL_W  = $clog2(MAX_W + 1);

  logic [MAX_W-1:0]  w_ext, h_ext, d_ext, biggest;
  logic [BL_W-1:0]   bit_len;
  logic [CNT_W-1:0]  levels;
  fmt_info_t         info;

  assign item_i.ready = push_ready_i;
  assign push_valid_o = item_i.valid;

  // Level count saturates at the chain limit
  always_comb begin
    if (32'(item_i.level_count) > 32'(MAX_LEVELS)) begin
      levels = CNT_W'(MAX_LEVELS);
    end else begin
      levels = CNT_W'(item_i.level_count);
    end
  end

  assign info = classify_fmt(item_i.format_code);

  // Full chain length: bit length of the largest dimension
  assign w_ext = MAX_W'(item_i.width);
  assign h_ext = MAX_W'(item_i.height);
  assign d_ext = MAX_W'(item_i.depth);

  always_comb begin
    biggest = w_ext;
    if (h_ext > biggest) begin
      biggest = h_ext;
    end
    if (d_ext > biggest) begin
      biggest = d_ext;
    end
    bit_len = '0;
    for (int i = 0; i < int'(MAX_W); i++) begin
      if (biggest[i]) begin
        bit_len = BL_W'(i + 1);
      end
    end
  end

  assign job_o = {item_i.width, item_i.height, item_i.depth, levels, info,
                  bit_len[FULL_W-1:0]};

endmodule

`default_nettype wire

[rtl/core/mcs_back.sv]
`default_nettype none

module mcs_back import mcs_pkg::*; #(
  parameter  int unsigned DIM_BITS   = DIM_BITS_DEF,
  parameter  int unsigned MAX_LEVELS = MAX_LEVELS_DEF,
  localparam int unsigned CNT_W      = $clog2(MAX_LEVELS + 1),
  localparam int unsigned JOB_W      = 2 * DIM_BITS + DEPTH_W + CNT_W
                                       + $bits(fmt_info_t) + FULL_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  output logic                  pop_ready_o,
  input  wire logic [JOB_W-1:0] job_i,
  mcs_out_if.source             result_o
);
  localparam int unsigned MB_W   = (DIM_BITS > DEPTH_W) ? DIM_BITS : DEPTH_W;
  localparam int unsigned XY_W   = 2 * DIM_BITS;
  localparam int unsigned PROD_W = XY_W + DEPTH_W;
  localparam int unsigned MUL_W  = XY_W + MB_W;
  localparam int unsigned TERM_W = PROD_W + 4;
  localparam int unsigned SUM_W  = ((TERM_W > TOTAL_W) ? TERM_W : TOTAL_W) + 1;

  back_state_e state_q, state_d;

  logic [DIM_BITS-1:0] w_q, w_d, h_q, h_d;
  logic [DEPTH_W-1:0]  d_q, d_d;
  logic [CNT_W-1:0]    left_q, left_d;
  fmt_info_t           info_q, info_d;
  logic [FULL_W-1:0]   full_q, full_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [TOTAL_W-1:0]  acc_q, acc_d;
  logic                ovf_q, ovf_d;

  // Job fields
  logic [DIM_BITS-1:0] job_w, job_h;
  logic [DEPTH_W-1:0]  job_d;
  logic [CNT_W-1:0]    job_n;
  fmt_info_t           job_info;
  logic [FULL_W-1:0]   job_full;

  logic [DIM_BITS-1:0] ew, eh, op_w, op_h;
  logic [DIM_BITS+1:0] w_round, h_round;
  logic [DEPTH_W-1:0]  ed;
  logic [XY_W-1:0]     mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [MUL_W-1:0]    mul_p;
  logic [TERM_W-1:0]   term, prod_x;
  logic [SUM_W-1:0]    total;

  assign {job_w, job_h, job_d, job_n, job_info, job_full} = job_i;

  // Clamp zero dimensions, round to 4x4 blocks for compressed formats
  assign ew      = (w_q == '0) ? DIM_BITS'(1) : w_q;
  assign eh      = (h_q == '0) ? DIM_BITS'(1) : h_q;
  assign ed      = (d_q == '0) ? DEPTH_W'(1) : d_q;
  assign w_round = (DIM_BITS + 2)'(ew) + (DIM_BITS + 2)'(3);
  assign h_round = (DIM_BITS + 2)'(eh) + (DIM_BITS + 2)'(3);
  assign op_w    = info_q.dxt ? w_round[DIM_BITS+1:2] : ew;
  assign op_h    = info_q.dxt ? h_round[DIM_BITS+1:2] : eh;

  // Shared multiplier: width x height, then area x depth
  always_comb begin
    if (state_q == BK_MUL_Z) begin
      mul_a = prod_q[XY_W-1:0];
      mul_b = MB_W'(ed);
    end else begin
      mul_a = XY_W'(op_w);
      mul_b = MB_W'(op_h);
    end
  end

  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // Bytes per unit as shift-add
  assign prod_x = TERM_W'(prod_q);

  always_comb begin
    case (info_q.scale)
      SCL_X1:  term = prod_x;
      SCL_X2:  term = prod_x << 1;
      SCL_X3:  term = prod_x + (prod_x << 1);
      SCL_X4:  term = prod_x << 2;
      SCL_X8:  term = prod_x << 3;
      SCL_X16: term = prod_x << 4;
      default: term = '0;
    endcase
  end

  assign total = SUM_W'(acc_q) + SUM_W'(term);

  // Level sequencer
  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    h_d     = h_q;
    d_d     = d_q;
    left_d  = left_q;
    info_d  = info_q;
    full_d  = full_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    pop_ready_o    = 1'b0;
    result_o.valid = 1'b0;
    case (state_q)
      BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          w_d     = job_w;
          h_d     = job_h;
          d_d     = job_d;
          left_d  = job_n;
          info_d  = job_info;
          full_d  = job_full;
          acc_d   = '0;
          ovf_d   = 1'b0;
          state_d = (job_n == '0) ? BK_DONE : BK_MUL_XY;
        end
      end
      BK_MUL_XY: begin
        prod_d  = mul_p[PROD_W-1:0];
        state_d = BK_MUL_Z;
      end
      BK_MUL_Z: begin
        prod_d  = mul_p[PROD_W-1:0];
        state_d = BK_ACC;
      end
      BK_ACC: begin
        if (!ovf_q) begin
          if (total > SUM_W'({TOTAL_W{1'b1}})) begin
            ovf_d = 1'b1;
            acc_d = '1;
          end else begin
            acc_d = total[TOTAL_W-1:0];
          end
        end
        w_d     = w_q >> 1;
        h_d     = h_q >> 1;
        d_d     = d_q >> 1;
        left_d  = left_q - 1'b1;
        state_d = (left_q == CNT_W'(1)) ? BK_DONE : BK_MUL_XY;
      end
      BK_DONE: begin
        result_o.valid = 1'b1;
        if (result_o.ready) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    h_q    <= h_d;
    d_q    <= d_d;
    left_q <= left_d;
    info_q <= info_d;
    full_q <= full_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    ovf_q  <= ovf_d;
  end

  assign result_o.total_bytes = acc_q;
  assign result_o.overflowed  = ovf_q;
  assign result_o.full_levels = full_q;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none

module testbench;
  import mcs_pkg::*;

  localparam int unsigned DIM_W = DIM_BITS_DEF;
  localparam int unsigned CLK_HALF = 2;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned END_CYCLES = 3 * MAX_LEVELS_DEF + 8;
  localparam int unsigned WATCHDOG_TIME = 2_500_000;
  localparam int unsigned REPORT_LIMIT = 10;

  // Format codes used by name in the directed tests
  localparam logic [FMT_W-1:0] FMT_24BPP_A = 32'd20;
  localparam logic [FMT_W-1:0] FMT_32BPP_A = 32'd21;
  localparam logic [FMT_W-1:0] FMT_16BPP_A = 32'd23;
  localparam logic [FMT_W-1:0] FMT_8BPP_A  = 32'd27;
  localparam logic [FMT_W-1:0] FMT_DXT2    = 32'h3254_5844;
  localparam logic [FMT_W-1:0] FMT_DXT3    = 32'h3354_5844;
  localparam logic [FMT_W-1:0] FMT_DXT4    = 32'h3454_5844;
  localparam logic [FMT_W-1:0] FMT_NONE    = 32'd0;
  localparam logic [FMT_W-1:0] FMT_ALL_ONES = 32'hFFFF_FFFF;

  localparam longint unsigned DXT1_BLOCK_BYTES = 8;
  localparam longint unsigned DXT_BLOCK_BYTES  = 16;
  localparam longint unsigned TOTAL_SAT        = 64'hFFFF_FFFF;

  // Uncompressed formats and their bits per pixel
  localparam int unsigned KNOWN_FMTS = 30;
  localparam logic [FMT_W-1:0] KNOWN_FMT [KNOWN_FMTS] = '{
    32'd20,
    32'd21, 32'd22, 32'd62, 32'd63, 32'd64, 32'd71, 32'd75, 32'd77, 32'd79, 32'd102,
    32'd23, 32'd24, 32'd25, 32'd26, 32'd29, 32'd30, 32'd40, 32'd51, 32'd60, 32'd61,
    32'd70, 32'd73, 32'd80, 32'd101,
    32'd27, 32'd28, 32'd41, 32'd50, 32'd52
  };
  localparam int unsigned KNOWN_BPP [KNOWN_FMTS] = '{
    24,
    32, 32, 32, 32, 32, 32, 32, 32, 32, 32,
    16, 16, 16, 16, 16, 16, 16, 16, 16, 16,
    16, 16, 16, 16,
    8, 8, 8, 8, 8
  };

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [DEPTH_W-1:0] depth;
    logic [COUNT_W-1:0] level_count;
    logic [FMT_W-1:0]   format_code;
  } texture_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_bytes;
    logic               overflowed;
    logic [FULL_W-1:0]  full_levels;
  } chain_size_t;

  typedef struct packed {
    texture_t    tex;
    chain_size_t size;
  } chain_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic gaps_on = 1'b1;
  logic result_ready = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned failures = 0;
  chain_entry_t expected_chains[$];
  chain_entry_t oldest;

  mcs_in_if #(.DIM_BITS(DIM_W)) item_if ();
  mcs_out_if result_if ();

  assign result_if.ready = result_ready;

  mip_chain_size_calculator #(
    .DIM_BITS  (DIM_W),
    .MAX_LEVELS(MAX_LEVELS_DEF)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Bits per pixel of an uncompressed format, 0 when unknown
  function automatic int unsigned pixel_bits_of(input logic [FMT_W-1:0] code);
    int unsigned bpp;
    bpp = 0;
    for (int i = 0; i < KNOWN_FMTS; i++) begin
      if (KNOWN_FMT[i] == code) bpp = KNOWN_BPP[i];
    end
    return bpp;
  endfunction

  // Exact byte total of the mip chain plus the full chain length
  function automatic chain_size_t predict_chain(input texture_t tex);
    longint unsigned w, h, d, ew, eh, ed, sum, level_size, blk;
    int unsigned levels, bpp, biggest, nbits;
    logic is_dxt;
    chain_size_t res;
    w = tex.width;
    h = tex.height;
    d = tex.depth;
    levels = (tex.level_count > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : tex.level_count;
    is_dxt = (tex.format_code >= FMT_DXT1) && (tex.format_code <= FMT_DXT5);
    blk = (tex.format_code == FMT_DXT1) ? DXT1_BLOCK_BYTES : DXT_BLOCK_BYTES;
    bpp = pixel_bits_of(tex.format_code);
    sum = 0;
    for (int i = 0; i < levels; i++) begin
      ew = (w == 0) ? 1 : w;
      eh = (h == 0) ? 1 : h;
      ed = (d == 0) ? 1 : d;
      if (is_dxt) begin
        level_size = ((ew + 3) >> 2) * ((eh + 3) >> 2) * ed * blk;
      end else begin
        level_size = (ew * eh * ed * bpp) >> 3;
      end
      sum += level_size;
      w >>= 1;
      h >>= 1;
      d >>= 1;
    end
    // Bit length of the largest level-zero dimension
    biggest = tex.width;
    if (tex.height > biggest) biggest = tex.height;
    if (tex.depth > biggest) biggest = tex.depth;
    nbits = 0;
    while (biggest != 0) begin
      biggest >>= 1;
      nbits++;
    end
    res.overflowed  = (sum > TOTAL_SAT);
    res.total_bytes = res.overflowed ? '1 : sum[TOTAL_W-1:0];
    res.full_levels = nbits[FULL_W-1:0];
    return res;
  endfunction

  function automatic texture_t make_tex(input int unsigned w, input int unsigned h,
                                        input int unsigned d, input int unsigned n,
                                        input logic [FMT_W-1:0] code);
    texture_t tex;
    tex.width       = DIM_W'(w);
    tex.height      = DIM_W'(h);
    tex.depth       = DEPTH_W'(d);
    tex.level_count = COUNT_W'(n);
    tex.format_code = code;
    return tex;
  endfunction

  // One transaction on the texture channel, with an optional idle burst first
  task automatic send_item(input texture_t tex);
    chain_entry_t entry;
    int unsigned idle;
    entry.tex  = tex;
    entry.size = predict_chain(tex);
    idle = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (idle) begin
      @(negedge clk_i);
      item_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    item_if.valid       <= 1'b1;
    item_if.width       <= tex.width;
    item_if.height      <= tex.height;
    item_if.depth       <= tex.depth;
    item_if.level_count <= tex.level_count;
    item_if.format_code <= tex.format_code;
    do @(posedge clk_i); while (!item_if.ready);
    expected_chains.push_back(entry);
  endtask

  task automatic note_failure(input string what, input chain_entry_t want,
                              input chain_size_t got);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $display("%s: w=%0d h=%0d d=%0d n=%0d fmt=%08h", what, want.tex.width,
               want.tex.height, want.tex.depth, want.tex.level_count, want.tex.format_code);
      $display("  expected total=%08h ovf=%0b full=%0d, got total=%08h ovf=%0b full=%0d",
               want.size.total_bytes, want.size.overflowed, want.size.full_levels,
               got.total_bytes, got.overflowed, got.full_levels);
    end
  endtask

  // Result side back-pressure in short random bursts
  always @(negedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      result_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      ready_hold <= $urandom_range(0, 2);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Compare every result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_ready) begin
      if (expected_chains.size() == 0) begin
        oldest = '0;
        note_failure("unexpected result", oldest,
                     {result_if.total_bytes, result_if.overflowed, result_if.full_levels});
      end else begin
        oldest = expected_chains.pop_front();
        if (result_if.total_bytes !== oldest.size.total_bytes ||
            result_if.overflowed !== oldest.size.overflowed ||
            result_if.full_levels !== oldest.size.full_levels) begin
          note_failure("mismatch", oldest,
                       {result_if.total_bytes, result_if.overflowed, result_if.full_levels});
        end
      end
    end
  end

  // Random stimulus helpers
  function automatic int unsigned rand_dim(input int unsigned bits);
    int unsigned v, mask;
    mask = (1 << bits) - 1;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 8);
      1: v = $urandom_range(0, 255);
      2, 3: v = $urandom;
      4: v = (1 << $urandom_range(0, bits - 1)) + $urandom_range(0, 2) - 1;
      default: v = mask;
    endcase
    return v & mask;
  endfunction

  function automatic logic [FMT_W-1:0] rand_format();
    logic [FMT_W-1:0] code;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: code = KNOWN_FMT[$urandom_range(0, KNOWN_FMTS - 1)];
      5, 6, 7: code = FMT_DXT1 + $urandom_range(0, 4);
      8: code = $urandom_range(0, 127);
      default: code = $urandom;
    endcase
    return code;
  endfunction

  function automatic texture_t rand_tex();
    int unsigned d, n;
    d = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : rand_dim(DEPTH_W);
    n = ($urandom_range(0, 3) != 0) ? $urandom_range(0, MAX_LEVELS_DEF)
                                    : $urandom_range(0, (1 << COUNT_W) - 1);
    return make_tex(rand_dim(DIM_W), rand_dim(DIM_W), d, n, rand_format());
  endfunction

  // Zero, largest and lopsided dimensions
  task automatic test_dimensions();
    send_item(make_tex(0, 0, 0, 1, FMT_32BPP_A));
    send_item(make_tex(16383, 16383, 2047, 16, FMT_32BPP_A));
    send_item(make_tex(5, 3, 2047, 3, FMT_8BPP_A));
    send_item(make_tex(1, 16383, 0, 15, FMT_16BPP_A));
    send_item(make_tex(16383, 1, 1, 14, FMT_24BPP_A));
  endtask

  // No levels, one level, the limit and counts past it
  task automatic test_level_counts();
    send_item(make_tex(100, 60, 1, 0, FMT_32BPP_A));
    send_item(make_tex(100, 60, 1, 1, FMT_32BPP_A));
    send_item(make_tex(100, 60, 1, MAX_LEVELS_DEF, FMT_32BPP_A));
    send_item(make_tex(100, 60, 1, MAX_LEVELS_DEF + 1, FMT_32BPP_A));
    send_item(make_tex(100, 60, 1, (1 << COUNT_W) - 1, FMT_32BPP_A));
  endtask

  // Each sizing rule, block formats and unknown codes around them
  task automatic test_formats();
    send_item(make_tex(5, 7, 1, 4, FMT_24BPP_A));
    send_item(make_tex(5, 7, 1, 4, FMT_32BPP_A));
    send_item(make_tex(5, 7, 1, 4, FMT_16BPP_A));
    send_item(make_tex(5, 7, 1, 4, FMT_8BPP_A));
    send_item(make_tex(5, 7, 2, 4, FMT_DXT1));
    send_item(make_tex(5, 7, 2, 4, FMT_DXT2));
    send_item(make_tex(5, 7, 2, 4, FMT_DXT3));
    send_item(make_tex(5, 7, 2, 4, FMT_DXT4));
    send_item(make_tex(5, 7, 2, 4, FMT_DXT5));
    send_item(make_tex(5, 7, 1, 4, FMT_NONE));
    send_item(make_tex(5, 7, 1, 4, FMT_DXT1 - 1));
    send_item(make_tex(5, 7, 1, 4, FMT_DXT5 + 1));
    send_item(make_tex(5, 7, 1, 4, FMT_ALL_ONES));
  endtask

  // Totals right below and right above the 32-bit limit
  task automatic test_overflow();
    send_item(make_tex(8192, 8192, 15, 1, FMT_32BPP_A));
    send_item(make_tex(8192, 8192, 16, 1, FMT_32BPP_A));
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_item(rand_tex());
  endtask

  // Sender holds off until the block has delivered everything
  task automatic test_drain_pause();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (expected_chains.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    item_if.valid       <= 1'b0;
    item_if.width       <= '0;
    item_if.height      <= '0;
    item_if.depth       <= '0;
    item_if.level_count <= '0;
    item_if.format_code <= '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_dimensions();
    test_level_counts();
    test_formats();
    test_overflow();
    test_random(1000);
    test_drain_pause();
    test_random(400);
    gaps_on = 1'b0;
    test_random(300);

    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (expected_chains.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(WATCHDOG_TIME);
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
